@@ hdl/adc_autorange_overvoltage_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the converter auto-ranging block
// Concurrent assertion shorthands sampled on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ADC_AUTORANGE_OVERVOLTAGE_ASSERT_SVH
`define ADC_AUTORANGE_OVERVOLTAGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADC_AR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adc_autorange_overvoltage: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ADC_AR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adc_autorange_overvoltage: assertion failed");

`endif

@@ hdl/adc_ar_pkg.sv @@
// ---------------------------------------------------------------------------
// adc_ar_pkg
// Shared types, constants and the full-scale table of the auto-ranging block.
// ---------------------------------------------------------------------------
package adc_ar_pkg;

    // Field widths
    localparam int CODE_W     = 16;
    localparam int MAG_W      = 17;
    localparam int GAIN_W     = 3;
    localparam int FS_W       = 13;
    localparam int OVMV_W     = 13;
    localparam int HOLD_W     = 20;
    localparam int HBL_W      = 16;
    localparam int SLOT_W     = 17;
    localparam int HITS_W     = 4;
    localparam int BATCH_W    = 2;
    localparam int WCH_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Number of code fields in an input word and gain fields in a result word
    localparam int PORT_CHANNELS = 4;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 40;

    // Parameter defaults
    localparam int CHANNELS_DEF       = 4;
    localparam int TOP_GAIN_INDEX_DEF = 5;
    localparam int TRIP_HITS_DEF      = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RANGE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERVOLTAGE_MV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BUF_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GAIN   = 3'd4;

    // Register reset values
    localparam logic                AUTO_RANGE_RST     = 1'b1;
    localparam logic [OVMV_W-1:0]   OVERVOLTAGE_MV_RST = 13'd6000;
    localparam logic [HOLD_W-1:0]   HOLD_SAMPLES_RST   = 20'd1000;
    localparam logic [HBL_W-1:0]    HALF_BUF_LEN_RST   = 16'd1024;
    localparam int                  INITIAL_GAIN_RST   = 0;

    // Batch codes
    localparam logic [BATCH_W-1:0] BATCH_NONE   = 2'd0;
    localparam logic [BATCH_W-1:0] BATCH_FIRST  = 2'd1;
    localparam logic [BATCH_W-1:0] BATCH_SECOND = 2'd2;

    // 0.95 of full scale: mag * 20 > 19 * 32768
    localparam logic [21:0] WIDEN_LIMIT = 22'd622592;

    typedef struct packed {
        logic              auto_range;
        logic [OVMV_W-1:0] overvoltage_mv;
        logic [HOLD_W-1:0] hold_samples;
    } chan_cfg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              changed;
        logic              trip;
    } chan_res_t;

    // Full scale in millivolts for a gain index; indices past 5 sit at 256 mV.
    function automatic logic [FS_W-1:0] fs_mv(input logic [GAIN_W-1:0] g);
        logic [FS_W-1:0] fs;
        unique case (g)
            3'd0:    fs = 13'd6144;
            3'd1:    fs = 13'd4096;
            3'd2:    fs = 13'd2048;
            3'd3:    fs = 13'd1024;
            3'd4:    fs = 13'd512;
            default: fs = 13'd256;
        endcase
        return fs;
    endfunction

endpackage

@@ hdl/adc_autorange_overvoltage.sv @@
// ---------------------------------------------------------------------------
// adc_autorange_overvoltage
// Four-channel converter front end with over-voltage watch and gain ranging.
// ---------------------------------------------------------------------------
// Usage: each word on the slave stream carries one signed 16-bit code per
// channel. For every accepted word the block returns exactly one word on the
// master stream with the buffer slot, the gain index of each channel after
// the sample, the gain change mask, the over-voltage warning and the batch
// flag. Registers are written over the cfg channel, which is always ready;
// write them only while no word is in flight.
// A word accepted into the input register has its result moved into the
// output register, while the channel state updates, once that register is
// empty or draining. One word per cycle is sustained while the receiver
// keeps up; the limiting path is the per-channel multiply and compare
// between those two registers. The output register decouples the sides, so
// a new word is taken while a finished result still waits. When the receiver
// stalls, the result holds; once the input register fills, s_tready drops.
// Reset empties both registers, clears the hit counts, the countdowns and the
// buffer position, loads the register defaults and sets every gain index to
// the reset value of initial_gain (widest range). Writing initial_gain later
// has no effect until the next reset, which restores its default anyway.
// ---------------------------------------------------------------------------
module adc_autorange_overvoltage #(
    parameter int CHANNELS       = adc_ar_pkg::CHANNELS_DEF,
    parameter int TOP_GAIN_INDEX = adc_ar_pkg::TOP_GAIN_INDEX_DEF,
    parameter int TRIP_HITS      = adc_ar_pkg::TRIP_HITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input words: code_ch0 [15:0], code_ch1 [31:16], code_ch2 [47:32],
    // code_ch3 [63:48]
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [adc_ar_pkg::IN_DATA_W-1:0]        s_tdata,
    // Result words: buffer_slot [16:0], gain_ch0 [19:17], gain_ch1 [22:20],
    // gain_ch2 [25:23], gain_ch3 [28:26], gain_changed [32:29],
    // overvoltage_warn [33], overvoltage_channel [35:34], batch_ready [37:36],
    // zero [39:38]
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [adc_ar_pkg::OUT_DATA_W-1:0]       m_tdata,
    // Register writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [adc_ar_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [adc_ar_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int NP = adc_ar_pkg::PORT_CHANNELS;
    localparam int GW = adc_ar_pkg::GAIN_W;

    // Configuration registers
    logic                                auto_range_reg;
    logic [adc_ar_pkg::OVMV_W-1:0]       ovmv_reg;
    logic [adc_ar_pkg::HOLD_W-1:0]       hold_reg;
    logic [adc_ar_pkg::HBL_W-1:0]        hbl_reg;
    adc_ar_pkg::chan_cfg_t               chan_cfg;

    // Pipeline registers
    logic                                in_valid_reg;
    logic [adc_ar_pkg::IN_DATA_W-1:0]    in_data_reg;
    logic                                out_valid_reg;
    logic [adc_ar_pkg::OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                                step;

    adc_ar_pkg::chan_res_t               res [CHANNELS];
    logic [GW-1:0]                       port_gain [NP];
    logic [NP-1:0]                       changed;
    logic                                warn;
    logic [adc_ar_pkg::WCH_W-1:0]        warn_ch;
    logic [adc_ar_pkg::SLOT_W-1:0]       slot;
    logic [adc_ar_pkg::BATCH_W-1:0]      batch;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_range_reg <= adc_ar_pkg::AUTO_RANGE_RST;
            ovmv_reg       <= adc_ar_pkg::OVERVOLTAGE_MV_RST;
            hold_reg       <= adc_ar_pkg::HOLD_SAMPLES_RST;
            hbl_reg        <= adc_ar_pkg::HALF_BUF_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                adc_ar_pkg::CFG_AUTO_RANGE:     auto_range_reg <= cfg_data[0];
                adc_ar_pkg::CFG_OVERVOLTAGE_MV: ovmv_reg <= cfg_data[adc_ar_pkg::OVMV_W-1:0];
                adc_ar_pkg::CFG_HOLD_SAMPLES:   hold_reg <= cfg_data;
                adc_ar_pkg::CFG_HALF_BUF_LEN:   hbl_reg  <= cfg_data[adc_ar_pkg::HBL_W-1:0];
                // The initial gain only matters at reset, where its default applies.
                adc_ar_pkg::CFG_INITIAL_GAIN:   ;
                default:                        ;
            endcase
        end
    end

    assign chan_cfg.auto_range     = auto_range_reg;
    assign chan_cfg.overvoltage_mv = ovmv_reg;
    assign chan_cfg.hold_samples   = hold_reg;

    // ---------------- handshake ----------------
    // The word in the input register is processed when the output register
    // is empty or is being drained in this cycle.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------- channels ----------------
    // Channels beyond the four carried in the word see a code of zero.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        logic signed [adc_ar_pkg::CODE_W-1:0] code;
        if (i < NP)
        begin : g_code
            assign code = in_data_reg[i*adc_ar_pkg::CODE_W +: adc_ar_pkg::CODE_W];
        end
        else
        begin : g_zero
            assign code = '0;
        end

        adc_ar_chan #(
            .TOP_GAIN_INDEX (TOP_GAIN_INDEX),
            .TRIP_HITS      (TRIP_HITS)
        ) u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (step),
            .code  (code),
            .cfg   (chan_cfg),
            .res   (res[i])
        );
    end

    for (genvar i = 0; i < NP; i++)
    begin : g_port
        if (i < CHANNELS)
        begin : g_used
            assign port_gain[i] = res[i].gain;
            assign changed[i]   = res[i].changed;
        end
        else
        begin : g_unused
            assign port_gain[i] = '0;
            assign changed[i]   = 1'b0;
        end
    end

    // Warning source is the highest channel that tripped, in its low two bits.
    always_comb
    begin
        warn    = 1'b0;
        warn_ch = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (res[i].trip)
            begin
                warn    = 1'b1;
                warn_ch = adc_ar_pkg::WCH_W'(i);
            end
        end
    end

    // ---------------- buffer position ----------------
    adc_ar_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .half_len (hbl_reg),
        .slot     (slot),
        .batch    (batch)
    );

    assign out_data_next = {2'b00, batch, warn_ch, warn, changed,
                            port_gain[3], port_gain[2], port_gain[1], port_gain[0],
                            slot};

endmodule

@@ hdl/adc_ar_chan.sv @@
// ---------------------------------------------------------------------------
// adc_ar_chan
// One channel: over-voltage hit counter and gain ranging with hold countdown.
// ---------------------------------------------------------------------------
module adc_ar_chan #(
    parameter int TOP_GAIN_INDEX = adc_ar_pkg::TOP_GAIN_INDEX_DEF,
    parameter int TRIP_HITS      = adc_ar_pkg::TRIP_HITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    step,
    input  logic signed [adc_ar_pkg::CODE_W-1:0]    code,
    input  adc_ar_pkg::chan_cfg_t                   cfg,
    output adc_ar_pkg::chan_res_t                   res
);

    localparam logic [adc_ar_pkg::GAIN_W-1:0] TOP_G =
        adc_ar_pkg::GAIN_W'(TOP_GAIN_INDEX);
    localparam logic [adc_ar_pkg::GAIN_W-1:0] GAIN_RST =
        (adc_ar_pkg::INITIAL_GAIN_RST > TOP_GAIN_INDEX) ? TOP_G
            : adc_ar_pkg::GAIN_W'(adc_ar_pkg::INITIAL_GAIN_RST);
    localparam logic [adc_ar_pkg::HITS_W-1:0] TRIP_LIM =
        adc_ar_pkg::HITS_W'(TRIP_HITS);

    logic [adc_ar_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic [adc_ar_pkg::HITS_W-1:0] hits_reg, hits_next;
    logic [adc_ar_pkg::HOLD_W-1:0] cd_reg, cd_next;

    logic [adc_ar_pkg::MAG_W-1:0]  mag;
    logic [27:0]                   prod;
    logic [27:0]                   ov_lim;
    logic                          over;
    logic [adc_ar_pkg::HITS_W-1:0] hits_inc;
    logic                          trip;
    logic [21:0]                   mag20;
    logic [adc_ar_pkg::GAIN_W-1:0] g_w;
    logic [adc_ar_pkg::GAIN_W:0]   up_ext;
    logic [adc_ar_pkg::GAIN_W-1:0] up;
    logic [30:0]                   low_lhs;
    logic [30:0]                   low_rhs;
    logic                          low;
    logic [adc_ar_pkg::HOLD_W-1:0] cd_cur;

    // Magnitude of the two's complement code, 0 .. 32768.
    assign mag = code[adc_ar_pkg::CODE_W-1]
        ? adc_ar_pkg::MAG_W'(-{code[adc_ar_pkg::CODE_W-1], code})
        : {1'b0, code};

    // Sample in millivolts times 32768.
    assign prod   = 28'(mag) * 28'(adc_ar_pkg::fs_mv(gain_reg));
    assign ov_lim = {cfg.overvoltage_mv, 15'd0};
    assign over   = prod > ov_lim;

    assign hits_inc = hits_reg + 4'd1;
    assign trip     = over && (hits_inc > TRIP_LIM);

    assign mag20 = 22'(mag) * 22'd20;
    assign g_w   = (mag20 > adc_ar_pkg::WIDEN_LIMIT && gain_reg != '0)
                   ? gain_reg - 3'd1 : gain_reg;

    assign up_ext = {1'b0, g_w} + 4'd1;
    assign up     = (up_ext > {1'b0, TOP_G}) ? TOP_G : up_ext[adc_ar_pkg::GAIN_W-1:0];

    // Below 0.8 of the next narrower full scale.
    assign low_lhs = 31'(prod) * 31'd5;
    assign low_rhs = {1'b0, adc_ar_pkg::fs_mv(up), 17'd0};
    assign low     = (low_lhs < low_rhs) && (g_w < TOP_G);

    assign cd_cur = (cd_reg == '0) ? cfg.hold_samples : cd_reg;

    always_comb
    begin
        gain_next = gain_reg;
        cd_next   = cd_reg;
        if (cfg.auto_range)
        begin
            gain_next = g_w;
            if (low)
            begin
                if (cd_cur <= 20'd1)
                begin
                    cd_next   = '0;
                    gain_next = up;
                end
                else
                begin
                    cd_next = cd_cur - 20'd1;
                end
            end
            else
            begin
                cd_next = cfg.hold_samples;
            end
        end
    end

    always_comb
    begin
        hits_next = hits_reg;
        if (over)
        begin
            hits_next = trip ? '0 : hits_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RST;
            hits_reg <= '0;
            cd_reg   <= '0;
        end
        else if (step)
        begin
            gain_reg <= gain_next;
            hits_reg <= hits_next;
            cd_reg   <= cd_next;
        end
    end

    assign res.gain    = gain_next;
    assign res.changed = gain_next != gain_reg;
    assign res.trip    = trip;

endmodule

@@ hdl/adc_ar_buf.sv @@
// ---------------------------------------------------------------------------
// adc_ar_buf
// Double-buffer write position with half and full batch signalling.
// ---------------------------------------------------------------------------
module adc_ar_buf (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [adc_ar_pkg::HBL_W-1:0]        half_len,
    output logic [adc_ar_pkg::SLOT_W-1:0]       slot,
    output logic [adc_ar_pkg::BATCH_W-1:0]      batch
);

    logic [adc_ar_pkg::SLOT_W-1:0] pos_reg, pos_next;
    logic [adc_ar_pkg::SLOT_W:0]   nxt;
    logic [adc_ar_pkg::SLOT_W:0]   half_ext;
    logic [adc_ar_pkg::SLOT_W:0]   full_ext;

    assign nxt      = {1'b0, pos_reg} + 18'd1;
    assign half_ext = {2'b00, half_len};
    assign full_ext = {1'b0, half_len, 1'b0};

    always_comb
    begin
        priority if (nxt == half_ext)
        begin
            batch    = adc_ar_pkg::BATCH_FIRST;
            pos_next = nxt[adc_ar_pkg::SLOT_W-1:0];
        end
        else if (nxt >= full_ext)
        begin
            batch    = adc_ar_pkg::BATCH_SECOND;
            pos_next = '0;
        end
        else
        begin
            batch    = adc_ar_pkg::BATCH_NONE;
            pos_next = nxt[adc_ar_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
        end
    end

    assign slot = pos_reg;

endmodule

@@ hdl/adc_ar_checker.sv @@
// ---------------------------------------------------------------------------
// adc_ar_checker
// Port-level checks of the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "adc_autorange_overvoltage_assert.svh"

module adc_ar_checker #(
    parameter int TOP_GAIN_INDEX = adc_ar_pkg::TOP_GAIN_INDEX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [adc_ar_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam logic [2:0] TOP_G = 3'(TOP_GAIN_INDEX);

    logic gains_in_range;

    assign gains_in_range = (m_tdata[19:17] <= TOP_G) && (m_tdata[22:20] <= TOP_G)
                         && (m_tdata[25:23] <= TOP_G) && (m_tdata[28:26] <= TOP_G);

    // A stalled result word stays put.
    `ADC_AR_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The source channel reads zero whenever no warning is raised.
    `ADC_AR_ASSERT_SAME(a_warn_channel, m_tvalid && !m_tdata[33], m_tdata[35:34] == 2'd0)

    // Only the first or second half can complete, never both.
    `ADC_AR_ASSERT_SAME(a_batch_code, m_tvalid, m_tdata[37:36] != 2'b11)

    // No gain index ranges past the narrowest range.
    `ADC_AR_ASSERT_SAME(a_gain_range, m_tvalid, gains_in_range)

endmodule

bind adc_autorange_overvoltage adc_ar_checker #(
    .TOP_GAIN_INDEX (TOP_GAIN_INDEX)
) u_adc_ar_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/adc_autorange_overvoltage_tb.sv @@
// ---------------------------------------------------------------------------
// adc_autorange_overvoltage_tb
// Self-checking bench for the four-channel auto-ranging converter front end.
// A queue of code words feeds a bursty stream driver. A clocked monitor
// predicts each result word from its own model of the gains, hit counts,
// narrowing countdowns and buffer position. It then checks every result
// word field by field against the oldest prediction. Registers are rewritten
// between phases while the block is idle, and the phases sweep the register
// extremes.
// ---------------------------------------------------------------------------
module adc_autorange_overvoltage_tb;
    import adc_ar_pkg::*;

    localparam int NUM_CH          = 4;
    localparam int TOP_GAIN        = 5;
    localparam int TRIP_COUNT      = 10;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 97;
    localparam int WATCHDOG_LIMIT  = 4000;

    // Indexes past the register list; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Magnitude bands used to build runs of codes per channel.
    typedef enum int {BAND_LOW, BAND_HIGH, BAND_FULL, BAND_MID} band_e;

    // Receiver stall patterns.
    typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_LONG} rx_mode_e;

    // Result word fields, laid out to match m_tdata[37:0].
    typedef struct packed {
        logic [BATCH_W-1:0] batch;
        logic [WCH_W-1:0]   trip_ch;
        logic               trip;
        logic [3:0]         changed;
        logic [GAIN_W-1:0]  g3;
        logic [GAIN_W-1:0]  g2;
        logic [GAIN_W-1:0]  g1;
        logic [GAIN_W-1:0]  g0;
        logic [SLOT_W-1:0]  slot;
    } result_t;

    // Clock, reset and DUT signals.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // Input words: code_ch0 [15:0], code_ch1 [31:16], code_ch2 [47:32],
    // code_ch3 [63:48]
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // Result words: buffer_slot [16:0], gain_ch0..3 [28:17], gain_changed
    // [32:29], overvoltage_warn [33], overvoltage_channel [35:34],
    // batch_ready [37:36], zero [39:38]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Words waiting to be sent and results waiting to be seen.
    logic [IN_DATA_W-1:0]  code_queue [$];
    result_t               result_queue [$];

    // Model state and the model's copy of the registers.
    logic [GAIN_W-1:0]     gain_q [NUM_CH];
    logic [HITS_W-1:0]     hit_count [NUM_CH];
    int unsigned           countdown [NUM_CH];
    int unsigned           wpos;
    logic                  ar_en;
    int unsigned           ov_limit;
    int unsigned           hold_len;
    int unsigned           half_len;
    // The initial gain is only loaded by reset, and reset also restores its
    // default, so a later write is kept here but never changes a gain.
    int unsigned           init_gain;

    // Handshake bookkeeping, idling controls and the error count.
    bit                    in_fire = 1'b0;
    bit                    tx_gappy = 1'b0;
    int                    tx_gap = 0;
    int                    tx_burst = 1;
    rx_mode_e              rx_mode = RX_STEADY;
    bit                    rx_stall = 1'b0;
    int                    rx_run = 0;
    int                    idle_cycles = 0;
    int                    result_index = 0;
    int                    mismatches = 0;

    adc_autorange_overvoltage u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 time unit clock period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Full scale in millivolts for a gain index; indices past 5 sit at 256 mV.
    function automatic int unsigned range_mv(input logic [GAIN_W-1:0] g);
        case (g)
            3'd0:    return 6144;
            3'd1:    return 4096;
            3'd2:    return 2048;
            3'd3:    return 1024;
            3'd4:    return 512;
            default: return 256;
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_codes(input int c0, input int c1,
                                                         input int c2, input int c3);
        return {16'(c3), 16'(c2), 16'(c1), 16'(c0)};
    endfunction

    // Draw one code from a magnitude band, with a random sign.
    function automatic logic [CODE_W-1:0] draw_code(input band_e b);
        int unsigned m;
        case (b)
            BAND_LOW:  m = $urandom_range(0, 12000);
            BAND_MID:  m = $urandom_range(12001, 30999);
            BAND_HIGH: m = $urandom_range(31000, 32768);
            default:   return 16'($urandom);
        endcase
        if (m == 32768)
            return 16'h8000;
        return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
    endfunction

    // Register write into the model, masked to each register's width.
    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_AUTO_RANGE:     ar_en = data[0];
            CFG_OVERVOLTAGE_MV: ov_limit = data[OVMV_W-1:0];
            CFG_HOLD_SAMPLES:   hold_len = data[HOLD_W-1:0];
            CFG_HALF_BUF_LEN:   half_len = data[HBL_W-1:0];
            CFG_INITIAL_GAIN:   init_gain = data[GAIN_W-1:0];
            default:            ;
        endcase
    endtask

    // Work out the result word for one accepted input word and queue it.
    task automatic predict_sample(input logic [IN_DATA_W-1:0] word);
        result_t           r;
        logic [CODE_W-1:0] code;
        longint unsigned   mag;
        longint unsigned   fs0;
        int unsigned       g0;
        int unsigned       g;
        int unsigned       up;
        int unsigned       nxt;
        r = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            code = word[16*i +: 16];
            mag = code[15] ? (65536 - code) : code;
            g0 = gain_q[i];
            g = g0;
            fs0 = range_mv(g0);

            // Over-voltage hit; the count restarts once it passes the trip count.
            if (mag * fs0 > longint'(ov_limit) * 32768)
            begin
                hit_count[i] = hit_count[i] + 1'b1;
                if (hit_count[i] > TRIP_COUNT)
                begin
                    r.trip = 1'b1;
                    r.trip_ch = 2'(i);
                    hit_count[i] = '0;
                end
            end

            if (ar_en)
            begin
                if (countdown[i] == 0)
                    countdown[i] = hold_len;
                // Widen at once above 95 percent of full scale.
                if (mag * 20 > 19 * 32768 && g > 0)
                    g = g - 1;
                up = (g + 1 > TOP_GAIN) ? TOP_GAIN : g + 1;
                // Narrow after a run of samples below 80 percent of the next
                // range, measured at the gain the sample was taken with.
                if (mag * fs0 * 5 < longint'(range_mv(3'(up))) * 4 * 32768 && g < TOP_GAIN)
                begin
                    if (countdown[i] <= 1)
                    begin
                        countdown[i] = 0;
                        g = up;
                    end
                    else
                        countdown[i] = countdown[i] - 1;
                end
                else
                    countdown[i] = hold_len;
                gain_q[i] = 3'(g);
            end
            if (gain_q[i] != 3'(g0))
                r.changed[i] = 1'b1;
        end

        // Double-buffer walk; a position at or past the end of the second
        // half wraps at once, which covers a zero length too.
        r.slot = SLOT_W'(wpos);
        nxt = wpos + 1;
        if (nxt == half_len)
        begin
            r.batch = BATCH_FIRST;
            wpos = nxt;
        end
        else if (nxt >= 2 * half_len)
        begin
            r.batch = BATCH_SECOND;
            wpos = 0;
        end
        else
        begin
            r.batch = BATCH_NONE;
            wpos = nxt;
        end
        wpos = wpos & 32'h1FFFF;

        r.g0 = gain_q[0];
        r.g1 = gain_q[1];
        r.g2 = gain_q[2];
        r.g3 = gain_q[3];
        result_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on result %0d: %s", $time, result_index, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // One register write over the cfg channel; the model follows on acceptance.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold off until every queued word is sent and every result has come,
    // then let the pipeline settle before touching registers.
    task automatic wait_for_drain();
        while (code_queue.size() != 0 || result_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Input driver. A word that is shown stays put until it is taken; in
    // gappy mode the sender runs bursts of random length with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !in_fire)
        begin
            // The word on the bus has not been taken yet, so it is held.
        end
        else if (tx_gap > 0)
        begin
            tx_gap = tx_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (code_queue.size() > 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= code_queue[0];
            if (tx_gappy)
            begin
                if (tx_burst <= 1)
                begin
                    tx_burst = $urandom_range(1, 12);
                    tx_gap   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                                           : $urandom_range(1, 4);
                end
                else
                    tx_burst = tx_burst - 1;
            end
        end
        else
            s_tvalid <= 1'b0;
    end

    // Receiver ready pattern: steady, short random chops, or long stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_run > 0)
                rx_run = rx_run - 1;
            else
            begin
                case (rx_mode)
                    RX_CHOPPY:
                    begin
                        rx_stall = !rx_stall;
                        rx_run = rx_stall ? $urandom_range(0, 2) : $urandom_range(0, 5);
                    end
                    RX_LONG:
                    begin
                        rx_stall = !rx_stall;
                        rx_run = rx_stall ? $urandom_range(5, 40) : $urandom_range(1, 20);
                    end
                    default:
                    begin
                        rx_stall = 1'b0;
                        rx_run = 0;
                    end
                endcase
            end
            m_tready <= !rx_stall;
        end
    end

    // Monitor: predict on every accepted input word, check every result word.
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n)
            in_fire = 1'b0;
        else
        begin
            in_fire = s_tvalid && s_tready;
            if (in_fire)
            begin
                predict_sample(s_tdata);
                void'(code_queue.pop_front());
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[37:0];
                if (result_queue.size() == 0)
                    report_mismatch("result word with no prediction waiting");
                else
                begin
                    want = result_queue.pop_front();
                    compare_field("buffer_slot", got.slot, want.slot);
                    compare_field("gain_ch0", got.g0, want.g0);
                    compare_field("gain_ch1", got.g1, want.g1);
                    compare_field("gain_ch2", got.g2, want.g2);
                    compare_field("gain_ch3", got.g3, want.g3);
                    compare_field("gain_changed", got.changed, want.changed);
                    compare_field("overvoltage_warn", got.trip, want.trip);
                    compare_field("overvoltage_channel", got.trip_ch, want.trip_ch);
                    compare_field("batch_ready", got.batch, want.batch);
                end
                result_index++;
            end
        end
    end

    // Watchdog: too many cycles in a row with no handshake anywhere.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL adc_autorange_overvoltage");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        band_e             band [NUM_CH];
        int                run_left [NUM_CH];
        logic [CODE_W-1:0] codes [NUM_CH];
        int                pick;

        // Model state after reset: register defaults, every gain at the
        // saturated reset value of the initial gain.
        ar_en     = AUTO_RANGE_RST;
        ov_limit  = OVERVOLTAGE_MV_RST;
        hold_len  = HOLD_SAMPLES_RST;
        half_len  = HALF_BUF_LEN_RST;
        init_gain = INITIAL_GAIN_RST;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            gain_q[ch]    = (INITIAL_GAIN_RST > TOP_GAIN) ? 3'(TOP_GAIN)
                                                          : 3'(INITIAL_GAIN_RST);
            hit_count[ch] = '0;
            countdown[ch] = 0;
            band[ch]      = BAND_LOW;
            run_left[ch]  = 0;
        end
        wpos = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed words at the reset settings: zero, both extremes, the
        // over-voltage edge at 32000/32001 and the widening edge at 31130.
        code_queue.push_back(pack_codes(0, 0, 0, 0));
        code_queue.push_back(pack_codes(32767, 32767, 32767, 32767));
        code_queue.push_back(pack_codes(-32768, -32768, -32768, -32768));
        code_queue.push_back(pack_codes(1, -1, 32000, 32001));
        code_queue.push_back(pack_codes(-32000, -32001, 31130, -31130));
        // Keep hitting channels 1 and 3 until both pass the trip count.
        repeat (11) code_queue.push_back(pack_codes(100, -32768, -5, 32767));
        wait_for_drain();

        // Zero hold and zero buffer length: every low sample narrows, every
        // word ends the second half, and any nonzero code is a hit.
        write_register(CFG_HOLD_SAMPLES, 20'd0);
        write_register(CFG_HALF_BUF_LEN, 20'd0);
        write_register(CFG_OVERVOLTAGE_MV, 20'd0);
        repeat (6) code_queue.push_back(pack_codes(0, 5, -5, 100));
        repeat (3) code_queue.push_back(pack_codes(-32768, 32767, 31130, -31200));
        repeat (2) code_queue.push_back(pack_codes(3, 0, -3, 0));
        wait_for_drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Upper data bits are set at random to check the register masks.
            write_register(CFG_AUTO_RANGE, {19'($urandom), (phase % 4) != 1});
            case (phase % 3)
                0:       write_register(CFG_OVERVOLTAGE_MV, 20'($urandom_range(0, 8191)));
                1:       write_register(CFG_OVERVOLTAGE_MV, 20'd6144);
                default: write_register(CFG_OVERVOLTAGE_MV, 20'hFFFFF);
            endcase
            case (phase % 5)
                0:       write_register(CFG_HOLD_SAMPLES, 20'd0);
                1:       write_register(CFG_HOLD_SAMPLES, 20'd1);
                2:       write_register(CFG_HOLD_SAMPLES, 20'($urandom_range(2, 12)));
                3:       write_register(CFG_HOLD_SAMPLES, 20'hFFFFF);
                default: write_register(CFG_HOLD_SAMPLES, 20'($urandom_range(2, 40)));
            endcase
            case (phase % 4)
                0:       write_register(CFG_HALF_BUF_LEN, 20'($urandom_range(1, 40)));
                1:       write_register(CFG_HALF_BUF_LEN, 20'd65535);
                2:       write_register(CFG_HALF_BUF_LEN, 20'd0);
                default: write_register(CFG_HALF_BUF_LEN, 20'($urandom_range(1, 4)));
            endcase
            write_register(CFG_INITIAL_GAIN, 20'($urandom_range(0, 7)));
            write_register(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 20'($urandom));

            // The first random phase runs with no idling on either side.
            tx_gappy = (phase != 0);
            tx_burst = 1;
            rx_mode  = (phase == 0) ? RX_STEADY : rx_mode_e'($urandom_range(0, 2));

            // Each channel runs in one magnitude band for a while, so that
            // long runs of low samples can narrow and bursts of high ones
            // widen; full-range codes mixed in act as noise.
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    if (run_left[ch] == 0)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 45)
                            band[ch] = BAND_LOW;
                        else if (pick < 65)
                            band[ch] = BAND_HIGH;
                        else if (pick < 85)
                            band[ch] = BAND_FULL;
                        else
                            band[ch] = BAND_MID;
                        run_left[ch] = $urandom_range(1, 25);
                    end
                    run_left[ch] = run_left[ch] - 1;
                    codes[ch] = draw_code(band[ch]);
                end
                code_queue.push_back({codes[3], codes[2], codes[1], codes[0]});
            end
            wait_for_drain();
        end

        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("PASS adc_autorange_overvoltage");
        else
            $display("FAIL adc_autorange_overvoltage");
        $finish;
    end

endmodule
